// ===== hw/rtl/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream loss monitor package
// Shared constants, codes and the summary record of the isochronous stream
// loss monitor.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CYCLE_WIDTH_DEF = 48;

    // Field widths of the items on the ports.
    localparam int STAMP_W   = 16;
    localparam int LEN_W     = 16;
    localparam int SYNC_W    = 4;
    localparam int GAP_W     = 16;
    localparam int CNT_OUT_W = 32;
    localparam int CYC_OUT_W = 48;

    // Bus timing: a 3-bit seconds field above a 13-bit cycle field, so stamps
    // repeat every 8 seconds.
    localparam int CYCLES_PER_SECOND = 8000;
    localparam int CYCLE_FIELD_W     = 13;
    localparam logic [CYCLE_FIELD_W-1:0] CYCLE_FIELD_MASK = 13'h1fff;
    localparam int WRAP_CYCLES       = 8 * CYCLES_PER_SECOND;
    localparam int WRAP_TWICE        = 2 * WRAP_CYCLES;
    // A stamp far behind the previous one folds in as if the difference had
    // first wrapped in a 32-bit word and was then reduced modulo the wrap.
    localparam longint unsigned WRAP_ALIAS = (64'd1 << 32) % WRAP_CYCLES;

    localparam logic [GAP_W-1:0] BURST_GAP_RESET = GAP_W'(16);

    localparam logic ACTION_PACKET  = 1'b0;
    localparam logic ACTION_SEG_END = 1'b1;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_SEGMENT = 1'b1;

    typedef struct packed {
        logic                 summary_kind;
        logic [CNT_OUT_W-1:0] packet_count;
        logic [CYC_OUT_W-1:0] cycle_span;
        logic [CNT_OUT_W-1:0] lost_count;
        logic [CNT_OUT_W-1:0] burst_count;
        logic [CNT_OUT_W-1:0] frame_count;
        logic [LEN_W-1:0]     length_min;
        logic [LEN_W-1:0]     length_max;
        logic [CYC_OUT_W-1:0] spacing_min;
        logic [CYC_OUT_W-1:0] spacing_max;
        logic [CYC_OUT_W-1:0] spacing_sum;
        logic                 last_of_run;
    } summary_t;

    // Seconds times 8000 plus the cycle field; at most 64191, so 16 bits.
    function automatic logic [STAMP_W-1:0] stamp_to_cycle(input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W:0] c;
        c = (STAMP_W+1)'(stamp[STAMP_W-1:CYCLE_FIELD_W]) * (STAMP_W+1)'(CYCLES_PER_SECOND)
            + (STAMP_W+1)'(stamp[CYCLE_FIELD_W-1:0] & CYCLE_FIELD_MASK);
        return c[STAMP_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/slm_if.sv =====
// ----------------------------------------------------------------------------
// Stream loss monitor channels
// Valid/ready channels for packet items and summary items.
// ----------------------------------------------------------------------------
interface slm_item_if
    import slm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [LEN_W-1:0]   payload_length;
    logic [SYNC_W-1:0]  sync_code;
    logic [STAMP_W-1:0] cycle_stamp;

    modport source (output valid, action, payload_length, sync_code, cycle_stamp,
                    input ready);
    modport sink (input valid, action, payload_length, sync_code, cycle_stamp,
                  output ready);
endinterface

interface slm_summary_if
    import slm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 summary_kind;
    logic [CNT_OUT_W-1:0] packet_count;
    logic [CYC_OUT_W-1:0] cycle_span;
    logic [CNT_OUT_W-1:0] lost_count;
    logic [CNT_OUT_W-1:0] burst_count;
    logic [CNT_OUT_W-1:0] frame_count;
    logic [LEN_W-1:0]     length_min;
    logic [LEN_W-1:0]     length_max;
    logic [CYC_OUT_W-1:0] spacing_min;
    logic [CYC_OUT_W-1:0] spacing_max;
    logic [CYC_OUT_W-1:0] spacing_sum;
    logic                 last_of_run;

    modport source (output valid, summary_kind, packet_count, cycle_span, lost_count,
                    burst_count, frame_count, length_min, length_max, spacing_min,
                    spacing_max, spacing_sum, last_of_run,
                    input ready);
    modport sink (input valid, summary_kind, packet_count, cycle_span, lost_count,
                  burst_count, frame_count, length_min, length_max, spacing_min,
                  spacing_max, spacing_sum, last_of_run,
                  output ready);
endinterface

// ===== hw/rtl/iso_stream_loss_monitor.sv =====
// ----------------------------------------------------------------------------
// Isochronous stream loss monitor
// Counts packets, lost cycles and loss bursts per frame and per segment and
// reports frame and segment summaries.
// ----------------------------------------------------------------------------
// The block accepts one packet or segment-end item per clock unless it
// stalls. An item is captured in an input register; once the result queue
// has room for two entries, its stamp distance, loss and burst bookkeeping
// and any summaries are formed in one pass and written to the three-entry
// result queue. Items that cause at most one summary flow at one per cycle
// while summaries are taken; a segment end with an open frame causes two
// summaries, and the single result port, which delivers one summary per
// cycle while ready is high, then sets the pace. burst_gap may be written
// only while no item is in flight. There is no clearing pass after reset.
module iso_stream_loss_monitor
    import slm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int CYCLE_WIDTH = CYCLE_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [GAP_W-1:0]  cfg_wdata,
    slm_item_if.sink          pkt,
    slm_summary_if.source     summary
);

    localparam int NW        = COUNT_WIDTH;
    localparam int CW        = CYCLE_WIDTH;
    localparam int OUT_DEPTH = 3;
    localparam int QW        = $clog2(OUT_DEPTH + 1);

    function automatic logic [NW-1:0] cnt_add(input logic [NW-1:0] a, input logic [NW-1:0] b);
        logic [NW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[NW] ? {NW{1'b1}} : s[NW-1:0];
    endfunction

    function automatic logic [CW-1:0] cyc_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [NW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[CNT_OUT_W-1:0];
    endfunction

    function automatic logic [CYC_OUT_W-1:0] cyc_out(input logic [CW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[CYC_OUT_W-1:0];
    endfunction

    // Input register.
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_action_reg;
    logic [LEN_W-1:0]   s1_len_reg;
    logic               s1_sync_reg;
    logic [STAMP_W-1:0] s1_now_reg;

    // Monitor state.
    logic [GAP_W-1:0]   burst_gap_reg, burst_gap_next;
    logic               seg_open_reg, seg_open_next;
    logic [STAMP_W-1:0] prev_cycle_reg, prev_cycle_next;
    logic [CW-1:0]      unwrapped_reg, unwrapped_next;
    logic [NW-1:0]      seg_packets_reg, seg_packets_next;
    logic [NW-1:0]      seg_loss_reg, seg_loss_next;
    logic [NW-1:0]      seg_burst_cnt_reg, seg_burst_cnt_next;
    logic [NW-1:0]      seg_frame_cnt_reg, seg_frame_cnt_next;
    // Last loss and burst start are kept as distances from the current
    // unwrapped cycle, with a flag for the "none" value of zero.
    logic               loss_none_reg, loss_none_next;
    logic [CW-1:0]      since_loss_reg, since_loss_next;
    logic               burst_none_reg, burst_none_next;
    logic [CW-1:0]      since_burst_reg, since_burst_next;
    logic [CW-1:0]      space_sum_reg, space_sum_next;
    logic [CW-1:0]      space_min_reg, space_min_next;
    logic [CW-1:0]      space_max_reg, space_max_next;
    logic               frame_open_reg, frame_open_next;
    logic [CW-1:0]      frame_start_reg, frame_start_next;
    logic [CW-1:0]      frame_since_reg, frame_since_next;
    logic [NW-1:0]      frame_packets_reg, frame_packets_next;
    logic [NW-1:0]      frame_lost_reg, frame_lost_next;
    logic [NW-1:0]      frame_bursts_reg, frame_bursts_next;
    logic [LEN_W-1:0]   len_low_reg, len_low_next;
    logic [LEN_W-1:0]   len_high_reg, len_high_next;

    // Result queue; entry 0 is the head.
    summary_t           q_reg [OUT_DEPTH];
    summary_t           q_next [OUT_DEPTH];
    logic [QW-1:0]      q_count_reg, q_count_next;

    logic               pop;
    logic               proc;
    logic               accept;
    logic [QW-1:0]      q_base;
    logic [18:0]        wrap_x;
    logic [18:0]        delta_raw;
    logic [STAMP_W-1:0] delta;
    summary_t           res0, res1;
    logic [1:0]         n_res;

    assign pop    = (q_count_reg != '0) && summary.ready;
    assign q_base = q_count_reg - QW'(pop);
    assign proc   = s1_valid_reg && (q_base <= QW'(OUT_DEPTH - 2));
    assign pkt.ready = !s1_valid_reg || proc;
    assign accept = pkt.valid && pkt.ready;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (proc)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // Cycle distance to the previous packet modulo one stamp wrap.
    always_comb
    begin
        wrap_x = {3'b000, s1_now_reg} + 19'(WRAP_CYCLES) - {3'b000, prev_cycle_reg};
        if (wrap_x[18])
            delta_raw = wrap_x + 19'(WRAP_ALIAS);
        else if (wrap_x < 19'(WRAP_CYCLES))
            delta_raw = wrap_x;
        else if (wrap_x < 19'(WRAP_TWICE))
            delta_raw = wrap_x - 19'(WRAP_CYCLES);
        else
            delta_raw = wrap_x - 19'(WRAP_TWICE);
        // A repeated stamp still advances by one cycle.
        delta = (delta_raw[STAMP_W-1:0] == '0) ? STAMP_W'(1) : delta_raw[STAMP_W-1:0];
    end

    always_comb
    begin
        logic [CW-1:0] u_new;
        logic [CW-1:0] dist_loss;
        logic [CW-1:0] spacing;
        logic [NW-1:0] missing;
        summary_t      frame_res;
        summary_t      seg_res;

        burst_gap_next     = cfg_we ? cfg_wdata : burst_gap_reg;
        seg_open_next      = seg_open_reg;
        prev_cycle_next    = prev_cycle_reg;
        unwrapped_next     = unwrapped_reg;
        seg_packets_next   = seg_packets_reg;
        seg_loss_next      = seg_loss_reg;
        seg_burst_cnt_next = seg_burst_cnt_reg;
        seg_frame_cnt_next = seg_frame_cnt_reg;
        loss_none_next     = loss_none_reg;
        since_loss_next    = since_loss_reg;
        burst_none_next    = burst_none_reg;
        since_burst_next   = since_burst_reg;
        space_sum_next     = space_sum_reg;
        space_min_next     = space_min_reg;
        space_max_next     = space_max_reg;
        frame_open_next    = frame_open_reg;
        frame_start_next   = frame_start_reg;
        frame_since_next   = frame_since_reg;
        frame_packets_next = frame_packets_reg;
        frame_lost_next    = frame_lost_reg;
        frame_bursts_next  = frame_bursts_reg;
        len_low_next       = len_low_reg;
        len_high_next      = len_high_reg;
        n_res              = 2'd0;
        res0               = '0;
        res1               = '0;
        u_new              = unwrapped_reg;
        dist_loss          = since_loss_reg + CW'(delta);
        spacing            = since_burst_reg + CW'(delta);
        missing            = NW'(delta) - NW'(1);

        frame_res              = '0;
        frame_res.summary_kind = KIND_FRAME;
        frame_res.length_min   = len_low_reg;
        frame_res.length_max   = len_high_reg;
        seg_res                = '0;

        if (proc)
        begin
            if (s1_action_reg == ACTION_SEG_END)
            begin
                if (seg_open_reg)
                begin
                    seg_res.summary_kind = KIND_SEGMENT;
                    seg_res.packet_count = cnt_out(seg_packets_reg);
                    seg_res.lost_count   = cnt_out(seg_loss_reg);
                    seg_res.burst_count  = cnt_out(seg_burst_cnt_reg);
                    seg_res.frame_count  = cnt_out(seg_frame_cnt_reg);
                    seg_res.spacing_min  = cyc_out(space_min_reg);
                    seg_res.spacing_max  = cyc_out(space_max_reg);
                    seg_res.spacing_sum  = cyc_out(space_sum_reg);
                    seg_res.last_of_run  = 1'b1;
                    if (frame_open_reg)
                    begin
                        frame_res.packet_count = cnt_out(frame_packets_reg);
                        frame_res.cycle_span   = cyc_out(frame_since_reg + CW'(1));
                        frame_res.lost_count   = cnt_out(frame_lost_reg);
                        frame_res.burst_count  = cnt_out(frame_bursts_reg);
                        res0  = frame_res;
                        res1  = seg_res;
                        n_res = 2'd2;
                        frame_open_next    = 1'b0;
                        frame_packets_next = '0;
                        frame_lost_next    = '0;
                        frame_bursts_next  = '0;
                        len_low_next       = '1;
                        len_high_next      = '0;
                    end
                    else
                    begin
                        res0  = seg_res;
                        n_res = 2'd1;
                    end
                    seg_open_next      = 1'b0;
                    seg_packets_next   = '0;
                    seg_loss_next      = '0;
                    seg_burst_cnt_next = '0;
                    seg_frame_cnt_next = '0;
                    space_sum_next     = '0;
                    space_min_next     = '1;
                    space_max_next     = '0;
                end
            end
            else
            begin
                if (!seg_open_reg)
                begin
                    // Segment start: no distance, burst history cleared.
                    seg_open_next    = 1'b1;
                    u_new            = '0;
                    loss_none_next   = 1'b1;
                    burst_none_next  = 1'b1;
                    since_loss_next  = '0;
                    since_burst_next = '0;
                    frame_since_next = '0 - frame_start_reg;
                end
                else
                begin
                    u_new            = unwrapped_reg + CW'(delta);
                    frame_since_next = frame_since_reg + CW'(delta);
                    since_loss_next  = dist_loss;
                    since_burst_next = spacing;
                    if (delta > STAMP_W'(1))
                    begin
                        seg_loss_next   = cnt_add(seg_loss_reg, missing);
                        frame_lost_next = cnt_add(frame_lost_reg, missing);
                        if (loss_none_reg || (dist_loss > CW'(burst_gap_reg)))
                        begin
                            if (!burst_none_reg)
                            begin
                                space_sum_next = cyc_add(space_sum_reg, spacing);
                                if (spacing < space_min_reg)
                                    space_min_next = spacing;
                                if (spacing > space_max_reg)
                                    space_max_next = spacing;
                            end
                            burst_none_next    = (u_new == '0);
                            since_burst_next   = '0;
                            seg_burst_cnt_next = cnt_add(seg_burst_cnt_reg, NW'(1));
                            frame_bursts_next  = cnt_add(frame_bursts_reg, NW'(1));
                        end
                        loss_none_next  = (u_new == '0);
                        since_loss_next = '0;
                    end
                end
                unwrapped_next   = u_new;
                prev_cycle_next  = s1_now_reg;
                seg_packets_next = cnt_add(seg_packets_reg, NW'(1));

                if (s1_sync_reg)
                begin
                    if (frame_open_reg)
                    begin
                        frame_res.packet_count = cnt_out(frame_packets_reg);
                        frame_res.cycle_span   = cyc_out(frame_since_next + CW'(1));
                        frame_res.lost_count   = cnt_out(frame_lost_next);
                        frame_res.burst_count  = cnt_out(frame_bursts_next);
                        frame_res.last_of_run  = 1'b1;
                        res0  = frame_res;
                        n_res = 2'd1;
                        frame_packets_next = '0;
                        frame_lost_next    = '0;
                        frame_bursts_next  = '0;
                        len_low_next       = '1;
                        len_high_next      = '0;
                    end
                    frame_open_next    = 1'b1;
                    frame_start_next   = u_new;
                    frame_since_next   = '0;
                    seg_frame_cnt_next = cnt_add(seg_frame_cnt_reg, NW'(1));
                end
                frame_packets_next = cnt_add(frame_packets_next, NW'(1));
                if (s1_len_reg < len_low_next)
                    len_low_next = s1_len_reg;
                if (s1_len_reg > len_high_next)
                    len_high_next = s1_len_reg;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
            if (pop && (i < OUT_DEPTH - 1))
                q_next[i] = q_reg[(i + 1) % OUT_DEPTH];
            if ((n_res != 2'd0) && (QW'(i) == q_base))
                q_next[i] = res0;
            if ((n_res == 2'd2) && (QW'(i) == q_base + QW'(1)))
                q_next[i] = res1;
        end
        q_count_next = q_base + QW'(n_res);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            q_count_reg       <= '0;
            burst_gap_reg     <= BURST_GAP_RESET;
            seg_open_reg      <= 1'b0;
            prev_cycle_reg    <= '0;
            unwrapped_reg     <= '0;
            seg_packets_reg   <= '0;
            seg_loss_reg      <= '0;
            seg_burst_cnt_reg <= '0;
            seg_frame_cnt_reg <= '0;
            loss_none_reg     <= 1'b1;
            since_loss_reg    <= '0;
            burst_none_reg    <= 1'b1;
            since_burst_reg   <= '0;
            space_sum_reg     <= '0;
            space_min_reg     <= '1;
            space_max_reg     <= '0;
            frame_open_reg    <= 1'b0;
            frame_start_reg   <= '0;
            frame_since_reg   <= '0;
            frame_packets_reg <= '0;
            frame_lost_reg    <= '0;
            frame_bursts_reg  <= '0;
            len_low_reg       <= '1;
            len_high_reg      <= '0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            q_count_reg       <= q_count_next;
            burst_gap_reg     <= burst_gap_next;
            seg_open_reg      <= seg_open_next;
            prev_cycle_reg    <= prev_cycle_next;
            unwrapped_reg     <= unwrapped_next;
            seg_packets_reg   <= seg_packets_next;
            seg_loss_reg      <= seg_loss_next;
            seg_burst_cnt_reg <= seg_burst_cnt_next;
            seg_frame_cnt_reg <= seg_frame_cnt_next;
            loss_none_reg     <= loss_none_next;
            since_loss_reg    <= since_loss_next;
            burst_none_reg    <= burst_none_next;
            since_burst_reg   <= since_burst_next;
            space_sum_reg     <= space_sum_next;
            space_min_reg     <= space_min_next;
            space_max_reg     <= space_max_next;
            frame_open_reg    <= frame_open_next;
            frame_start_reg   <= frame_start_next;
            frame_since_reg   <= frame_since_next;
            frame_packets_reg <= frame_packets_next;
            frame_lost_reg    <= frame_lost_next;
            frame_bursts_reg  <= frame_bursts_next;
            len_low_reg       <= len_low_next;
            len_high_reg      <= len_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= pkt.action;
            s1_len_reg    <= pkt.payload_length;
            s1_sync_reg   <= (pkt.sync_code != '0);
            s1_now_reg    <= stamp_to_cycle(pkt.cycle_stamp);
        end
        for (int i = 0; i < OUT_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    assign summary.valid        = (q_count_reg != '0);
    assign summary.summary_kind = q_reg[0].summary_kind;
    assign summary.packet_count = q_reg[0].packet_count;
    assign summary.cycle_span   = q_reg[0].cycle_span;
    assign summary.lost_count   = q_reg[0].lost_count;
    assign summary.burst_count  = q_reg[0].burst_count;
    assign summary.frame_count  = q_reg[0].frame_count;
    assign summary.length_min   = q_reg[0].length_min;
    assign summary.length_max   = q_reg[0].length_max;
    assign summary.spacing_min  = q_reg[0].spacing_min;
    assign summary.spacing_max  = q_reg[0].spacing_max;
    assign summary.spacing_sum  = q_reg[0].spacing_sum;
    assign summary.last_of_run  = q_reg[0].last_of_run;

endmodule

// ===== hw/rtl/slm_checker.sv =====
// ----------------------------------------------------------------------------
// Stream loss monitor checker
// Port-level assertions on the summary channel of the loss monitor.
// ----------------------------------------------------------------------------
module slm_checker
    import slm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 summary_valid,
    input logic                 summary_ready,
    input logic                 summary_kind,
    input logic [CNT_OUT_W-1:0] packet_count,
    input logic [CYC_OUT_W-1:0] cycle_span,
    input logic [CNT_OUT_W-1:0] frame_count,
    input logic [LEN_W-1:0]     length_min,
    input logic [LEN_W-1:0]     length_max,
    input logic [CYC_OUT_W-1:0] spacing_min,
    input logic [CYC_OUT_W-1:0] spacing_max,
    input logic [CYC_OUT_W-1:0] spacing_sum,
    input logic                 last_of_run
);

    // Set after a delivered item that was not the last of its run.
    logic pend_seg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_seg_reg <= 1'b0;
        else if (summary_valid && summary_ready)
            pend_seg_reg <= !last_of_run;
    end

    // Only a segment end yields two items, so the second must be its summary.
    assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid && pend_seg_reg |-> summary_kind == KIND_SEGMENT && last_of_run)
        else $error("item after a non-final item is not a final segment summary");

    assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid && summary_kind == KIND_SEGMENT |-> last_of_run)
        else $error("segment summary not marked as final item");

    assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid && summary_kind == KIND_FRAME |->
            frame_count == '0 && spacing_min == '0 && spacing_max == '0 &&
            spacing_sum == '0)
        else $error("frame summary carries segment-only fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid && summary_kind == KIND_SEGMENT |->
            cycle_span == '0 && length_min == '0 && length_max == '0)
        else $error("segment summary carries frame-only fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        summary_valid && !summary_ready |=>
            summary_valid && $stable(packet_count) && $stable(summary_kind))
        else $error("stalled summary item changed");

endmodule

bind iso_stream_loss_monitor slm_checker u_slm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .summary_valid (summary.valid),
    .summary_ready (summary.ready),
    .summary_kind  (summary.summary_kind),
    .packet_count  (summary.packet_count),
    .cycle_span    (summary.cycle_span),
    .frame_count   (summary.frame_count),
    .length_min    (summary.length_min),
    .length_max    (summary.length_max),
    .spacing_min   (summary.spacing_min),
    .spacing_max   (summary.spacing_max),
    .spacing_sum   (summary.spacing_sum),
    .last_of_run   (summary.last_of_run)
);

// ===== tb/loss_summary_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stream loss summary checker
// Watches the packet and summary channels of the loss monitor, predicts the
// frame and segment summaries of every accepted item and compares each
// accepted summary, field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module loss_summary_checker
    import slm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [GAP_W-1:0] cfg_wdata,
    slm_item_if              pkt,
    slm_summary_if           summary,
    output int               mismatches,
    output int               summaries_due
);

    logic [GAP_W-1:0]     gap_limit;
    logic                 seg_live;
    logic                 frame_live;
    logic [STAMP_W-1:0]   prior_cycle;
    logic [CYC_OUT_W-1:0] position;
    logic [CYC_OUT_W-1:0] last_loss_at;
    logic [CYC_OUT_W-1:0] burst_began;
    logic [CYC_OUT_W-1:0] frame_began;
    logic [CNT_OUT_W-1:0] seg_pkts;
    logic [CNT_OUT_W-1:0] lost_in_seg;
    logic [CNT_OUT_W-1:0] bursts_in_seg;
    logic [CNT_OUT_W-1:0] frames_in_seg;
    logic [CNT_OUT_W-1:0] frm_pkts;
    logic [CNT_OUT_W-1:0] frm_lost;
    logic [CNT_OUT_W-1:0] frm_bursts;
    logic [CYC_OUT_W-1:0] spacing_total;
    logic [CYC_OUT_W-1:0] spacing_least;
    logic [CYC_OUT_W-1:0] spacing_most;
    logic [LEN_W-1:0]     len_least;
    logic [LEN_W-1:0]     len_most;
    summary_t             due_summaries[$];
    int                   seen_summaries;

    function automatic logic [CNT_OUT_W-1:0] count_add(input logic [CNT_OUT_W-1:0] a,
                                                       input logic [CNT_OUT_W-1:0] b);
        logic [CNT_OUT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_OUT_W] ? '1 : s[CNT_OUT_W-1:0];
    endfunction

    function automatic logic [CYC_OUT_W-1:0] cycles_add(input logic [CYC_OUT_W-1:0] a,
                                                        input logic [CYC_OUT_W-1:0] b);
        logic [CYC_OUT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CYC_OUT_W] ? '1 : s[CYC_OUT_W-1:0];
    endfunction

    task automatic clear_frame();
        frame_live = 1'b0;
        frm_pkts   = '0;
        frm_lost   = '0;
        frm_bursts = '0;
        len_least  = '1;
        len_most   = '0;
    endtask

    task automatic clear_segment();
        seg_live      = 1'b0;
        seg_pkts      = '0;
        lost_in_seg   = '0;
        bursts_in_seg = '0;
        frames_in_seg = '0;
        spacing_total = '0;
        spacing_least = '1;
        spacing_most  = '0;
    endtask

    task automatic push_frame_summary(input logic last);
        summary_t s;
        s              = '0;
        s.summary_kind = KIND_FRAME;
        s.packet_count = frm_pkts;
        s.cycle_span   = position - frame_began + CYC_OUT_W'(1);
        s.lost_count   = frm_lost;
        s.burst_count  = frm_bursts;
        s.length_min   = len_least;
        s.length_max   = len_most;
        s.last_of_run  = last;
        due_summaries.push_back(s);
        clear_frame();
    endtask

    // Works out the summaries that one accepted item causes.
    task automatic account_item(input logic act, input logic [LEN_W-1:0] len,
                                input logic [SYNC_W-1:0] sy,
                                input logic [STAMP_W-1:0] st);
        summary_t             s;
        int unsigned          now;
        int unsigned          wrap;
        int unsigned          step;
        logic [CYC_OUT_W-1:0] since_loss;
        logic [CYC_OUT_W-1:0] spacing;
        wrap = WRAP_CYCLES;
        if (act == ACTION_SEG_END)
        begin
            if (!seg_live)
                return;
            if (frame_live)
                push_frame_summary(1'b0);
            s               = '0;
            s.summary_kind  = KIND_SEGMENT;
            s.packet_count  = seg_pkts;
            s.lost_count    = lost_in_seg;
            s.burst_count   = bursts_in_seg;
            s.frame_count   = frames_in_seg;
            s.spacing_min   = spacing_least;
            s.spacing_max   = spacing_most;
            s.spacing_sum   = spacing_total;
            s.last_of_run   = 1'b1;
            due_summaries.push_back(s);
            clear_segment();
            return;
        end

        now = 32'(st[STAMP_W-1:CYCLE_FIELD_W]) * 32'(CYCLES_PER_SECOND)
              + 32'(st[CYCLE_FIELD_W-1:0]);
        if (!seg_live)
        begin
            seg_live     = 1'b1;
            position     = '0;
            last_loss_at = '0;
            burst_began  = '0;
        end
        else
        begin
            // The difference is taken in 32-bit unsigned arithmetic, so a stamp far
            // behind the previous one folds in through the 32-bit wrap.
            step = (now + wrap - 32'(prior_cycle)) % wrap;
            if (step == 0)
                step = 1;
            position = position + CYC_OUT_W'(step);
            if (step > 1)
            begin
                lost_in_seg = count_add(lost_in_seg, CNT_OUT_W'(step - 1));
                frm_lost    = count_add(frm_lost, CNT_OUT_W'(step - 1));
                since_loss  = position - last_loss_at;
                if (last_loss_at == '0 || since_loss > CYC_OUT_W'(gap_limit))
                begin
                    if (burst_began != '0)
                    begin
                        spacing       = position - burst_began;
                        spacing_total = cycles_add(spacing_total, spacing);
                        if (spacing < spacing_least)
                            spacing_least = spacing;
                        if (spacing > spacing_most)
                            spacing_most = spacing;
                    end
                    burst_began   = position;
                    bursts_in_seg = count_add(bursts_in_seg, CNT_OUT_W'(1));
                    frm_bursts    = count_add(frm_bursts, CNT_OUT_W'(1));
                end
                last_loss_at = position;
            end
        end
        prior_cycle = now[STAMP_W-1:0];
        seg_pkts    = count_add(seg_pkts, CNT_OUT_W'(1));

        if (sy != '0)
        begin
            if (frame_live)
                push_frame_summary(1'b1);
            frame_live    = 1'b1;
            frame_began   = position;
            frames_in_seg = count_add(frames_in_seg, CNT_OUT_W'(1));
        end
        // Packets seen while no frame is open carry into the next frame.
        frm_pkts = count_add(frm_pkts, CNT_OUT_W'(1));
        if (len < len_least)
            len_least = len;
        if (len > len_most)
            len_most = len;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t summary %0d: %s is %0h, expected %0h",
                 $realtime, seen_summaries, what, got, want);
        mismatches++;
    endtask

    task automatic check_summary(input summary_t got, input summary_t want);
        if (got.summary_kind !== want.summary_kind)
            report_mismatch("summary_kind", 64'(got.summary_kind), 64'(want.summary_kind));
        if (got.packet_count !== want.packet_count)
            report_mismatch("packet_count", 64'(got.packet_count), 64'(want.packet_count));
        if (got.cycle_span !== want.cycle_span)
            report_mismatch("cycle_span", 64'(got.cycle_span), 64'(want.cycle_span));
        if (got.lost_count !== want.lost_count)
            report_mismatch("lost_count", 64'(got.lost_count), 64'(want.lost_count));
        if (got.burst_count !== want.burst_count)
            report_mismatch("burst_count", 64'(got.burst_count), 64'(want.burst_count));
        if (got.frame_count !== want.frame_count)
            report_mismatch("frame_count", 64'(got.frame_count), 64'(want.frame_count));
        if (got.length_min !== want.length_min)
            report_mismatch("length_min", 64'(got.length_min), 64'(want.length_min));
        if (got.length_max !== want.length_max)
            report_mismatch("length_max", 64'(got.length_max), 64'(want.length_max));
        if (got.spacing_min !== want.spacing_min)
            report_mismatch("spacing_min", 64'(got.spacing_min), 64'(want.spacing_min));
        if (got.spacing_max !== want.spacing_max)
            report_mismatch("spacing_max", 64'(got.spacing_max), 64'(want.spacing_max));
        if (got.spacing_sum !== want.spacing_sum)
            report_mismatch("spacing_sum", 64'(got.spacing_sum), 64'(want.spacing_sum));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        summary_t got;
        if (!rst_n)
        begin
            gap_limit    = BURST_GAP_RESET;
            prior_cycle  = '0;
            position     = '0;
            last_loss_at = '0;
            burst_began  = '0;
            frame_began  = '0;
            clear_segment();
            clear_frame();
            due_summaries.delete();
            seen_summaries = 0;
            mismatches     = 0;
            summaries_due  = 0;
        end
        else
        begin
            if (cfg_we)
                gap_limit = cfg_wdata;
            if (pkt.valid && pkt.ready)
                account_item(pkt.action, pkt.payload_length, pkt.sync_code, pkt.cycle_stamp);
            if (summary.valid && summary.ready)
            begin
                got.summary_kind = summary.summary_kind;
                got.packet_count = summary.packet_count;
                got.cycle_span   = summary.cycle_span;
                got.lost_count   = summary.lost_count;
                got.burst_count  = summary.burst_count;
                got.frame_count  = summary.frame_count;
                got.length_min   = summary.length_min;
                got.length_max   = summary.length_max;
                got.spacing_min  = summary.spacing_min;
                got.spacing_max  = summary.spacing_max;
                got.spacing_sum  = summary.spacing_sum;
                got.last_of_run  = summary.last_of_run;
                if (due_summaries.size() == 0)
                    report_mismatch("unexpected summary, kind", 64'(got.summary_kind), 64'(0));
                else
                    check_summary(got, due_summaries.pop_front());
                seen_summaries++;
            end
            summaries_due = due_summaries.size();
        end
    end

endmodule

// ===== tb/iso_stream_loss_monitor_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Isochronous stream loss monitor test
// Drives directed and random packet and segment-end items with random idle
// bursts on both channels, sweeps the burst gap register and lets the checker
// predict and compare every frame and segment summary.
// ----------------------------------------------------------------------------
module iso_stream_loss_monitor_test;
    import slm_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int PRESSURE_ITEMS = 24;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [GAP_W-1:0] cfg_wdata;
    int               mismatches;
    int               summaries_due;
    int               quiet_cycles;
    bit               tx_idle_on;
    bit               rx_idle_on;
    bit               hold_request;
    int unsigned      cursor;

    slm_item_if    pkt_ch();
    slm_summary_if sum_ch();

    iso_stream_loss_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pkt       (pkt_ch),
        .summary   (sum_ch)
    );

    loss_summary_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pkt           (pkt_ch),
        .summary       (sum_ch),
        .mismatches    (mismatches),
        .summaries_due (summaries_due)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [STAMP_W-1:0] cursor_stamp(input int unsigned c);
        int unsigned sec;
        int unsigned cyc;
        sec = c / CYCLES_PER_SECOND;
        cyc = c % CYCLES_PER_SECOND;
        return {sec[2:0], cyc[CYCLE_FIELD_W-1:0]};
    endfunction

    // Offers one item, waits for the edge where it is taken and now and then adds a random idle burst.
    task automatic send_item(input logic act, input logic [LEN_W-1:0] len,
                             input logic [SYNC_W-1:0] sy, input logic [STAMP_W-1:0] st);
        pkt_ch.valid          <= 1'b1;
        pkt_ch.action         <= act;
        pkt_ch.payload_length <= len;
        pkt_ch.sync_code      <= sy;
        pkt_ch.cycle_stamp    <= st;
        do
            @(posedge clk);
        while (!pkt_ch.ready);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            pkt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // A packet that follows the running stamp cursor, now and then with lost
    // cycles, a repeated stamp or a frame start, or an orderly segment end.
    task automatic send_stream_item();
        int unsigned r;
        int unsigned step;
        logic [SYNC_W-1:0] sy;
        if ($urandom_range(0, 99) < 2)
        begin
            send_item(ACTION_SEG_END, LEN_W'($urandom), SYNC_W'($urandom),
                      STAMP_W'($urandom));
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 68)
            step = 1;
        else if (r < 74)
            step = 0;
        else if (r < 92)
            step = $urandom_range(2, 40);
        else if (r < 98)
            step = $urandom_range(41, 3000);
        else
            step = $urandom_range(3001, WRAP_CYCLES - 1);
        cursor = (cursor + step) % WRAP_CYCLES;
        sy = ($urandom_range(0, 9) == 0) ? SYNC_W'($urandom_range(1, 15)) : '0;
        send_item(ACTION_PACKET, LEN_W'($urandom), sy, cursor_stamp(cursor));
    endtask

    task automatic send_noise_item();
        logic act;
        logic [SYNC_W-1:0] sy;
        act = ($urandom_range(0, 7) == 0) ? ACTION_SEG_END : ACTION_PACKET;
        sy  = ($urandom_range(0, 3) == 0) ? SYNC_W'($urandom) : '0;
        send_item(act, LEN_W'($urandom), sy, STAMP_W'($urandom));
    endtask

    // The sender rests until every summary due has arrived, then settles so that
    // items that produce nothing are through as well.
    task automatic drain_results();
        pkt_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (summaries_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_burst_gap(input logic [GAP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall bursts, and one long hold when asked for.
    initial
    begin
        int stall_left;
        stall_left = 0;
        sum_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                sum_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD - 1;
                sum_ch.ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left   = $urandom_range(0, 14);
                sum_ch.ready <= 1'b0;
            end
            else
                sum_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pkt_ch.valid && pkt_ch.ready) || (sum_ch.valid && sum_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT - 1)
        begin
            $display("iso_stream_loss_monitor test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        pkt_ch.valid          <= 1'b0;
        pkt_ch.action         <= ACTION_PACKET;
        pkt_ch.payload_length <= '0;
        pkt_ch.sync_code      <= '0;
        pkt_ch.cycle_stamp    <= '0;
        quiet_cycles          = 0;
        tx_idle_on            = 1'b1;
        rx_idle_on            = 1'b1;
        hold_request          = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items, with the burst gap at its reset value.
        send_item(ACTION_SEG_END, '1, '1, '1);               // no segment yet
        send_item(ACTION_PACKET, '1, '0, cursor_stamp(0));   // segment start, no frame
        send_item(ACTION_PACKET, '0, '0, cursor_stamp(0));   // repeated stamp
        send_item(ACTION_PACKET, 16'd100, '1, cursor_stamp(5));
        send_item(ACTION_PACKET, 16'd200, '0, cursor_stamp(9));
        send_item(ACTION_PACKET, 16'd300, '0, cursor_stamp(40));
        send_item(ACTION_PACKET, 16'd17, '0, {3'd0, 13'h1fff}); // cycle field past 7999
        send_item(ACTION_PACKET, 16'd5, 4'd1, '1);
        send_item(ACTION_PACKET, 16'd9, '0, '0);             // far behind the last stamp
        send_item(ACTION_PACKET, 16'd65534, '0, cursor_stamp(8000));
        send_item(ACTION_PACKET, 16'd1, 4'd8, cursor_stamp(8001));
        send_item(ACTION_SEG_END, '0, '0, '0);               // frame and segment
        send_item(ACTION_SEG_END, '0, '0, '0);               // segment already closed
        send_item(ACTION_PACKET, 16'd7, '0, 16'h1234);
        send_item(ACTION_PACKET, 16'd70, '0, 16'h1237);
        send_item(ACTION_SEG_END, '0, '0, '0);               // no frame open
        send_item(ACTION_PACKET, 16'd3, 4'd2, cursor_stamp(100));
        send_item(ACTION_PACKET, 16'd4, 4'd4, cursor_stamp(100));
        send_item(ACTION_PACKET, 16'd6, '0, cursor_stamp(WRAP_CYCLES - 1));
        send_item(ACTION_PACKET, '1, '0, cursor_stamp(0));   // wrap of the stamp
        send_item(ACTION_PACKET, '0, 4'd15, cursor_stamp(30));
        send_item(ACTION_SEG_END, '1, '1, '1);

        cursor = $urandom_range(0, WRAP_CYCLES - 1);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: set_burst_gap('0);
                1: set_burst_gap('1);
                2: set_burst_gap(GAP_W'(1));
                3: set_burst_gap(BURST_GAP_RESET);
                4: set_burst_gap(GAP_W'($urandom));
                default: set_burst_gap(GAP_W'($urandom_range(2, 60)));
            endcase
            tx_idle_on = (ph < 2) || (ph < PHASES - 2 && $urandom_range(0, 3) != 0);
            rx_idle_on = (ph < 2) || (ph < PHASES - 2 && $urandom_range(0, 3) != 0);
            if (ph == 2)
            begin
                // Frame starts back to back while the result side holds off, so
                // the result queue fills and the input stalls.
                tx_idle_on   = 1'b0;
                hold_request = 1'b1;
                for (int i = 0; i < PRESSURE_ITEMS; i++)
                begin
                    cursor = (cursor + $urandom_range(1, 5)) % WRAP_CYCLES;
                    send_item(ACTION_PACKET, LEN_W'($urandom), SYNC_W'($urandom_range(1, 15)),
                              cursor_stamp(cursor));
                end
                tx_idle_on = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise_item();
                else
                    send_stream_item();
            end
        end

        drain_results();
        if (mismatches == 0 && summaries_due == 0)
            $display("iso_stream_loss_monitor test passed");
        else
            $display("iso_stream_loss_monitor test failed");
        $finish;
    end

endmodule
